### rtl/fpd_pkg.sv
// Shared types and constants for the flight phase detector.
`default_nettype none

package fpd_pkg;

   // Sample field widths.
   localparam int NUM_LANES = 6;
   localparam int SMP_W     = 16;
   localparam int P_W       = 24;
   localparam int PHASE_W   = 3;
   localparam int EVENT_W   = 2;

   // Deviation multiplier registers.
   localparam int              MULT_W    = 4;
   localparam int              MULT_MAX  = (1 << MULT_W) - 1;
   localparam logic [MULT_W-1:0] KM_RESET = 4'd5;
   localparam logic [MULT_W-1:0] KL_RESET = 4'd2;

   // Register indexes on the configuration port.
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_LIFTOFF_APOGEE_MULT = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_LANDING_MULT        = 1'b1;

   // Calibration length per half (a power of two, so averaging is a shift).
   localparam int CAL_HALF  = 8;
   localparam int CAL_LOG2  = $clog2(CAL_HALF);
   localparam int CAL_RND   = CAL_HALF / 2;
   localparam int CNT_W     = $clog2(2 * CAL_HALF);
   localparam logic [CNT_W-1:0] CAL_MID  = CNT_W'(CAL_HALF - 1);
   localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(2 * CAL_HALF - 1);

   // Flight mean tracking: (16x + 3m + 2) / 4.
   localparam int TRK_RND   = 2;
   localparam int TRK_SHIFT = 2;

   // Q.4 storage widths: motion mean, motion deviation, pressure mean and deviation.
   localparam int MM_W = 22;
   localparam int MD_W = 24;
   localparam int PM_W = 28;
   localparam int PD_W = 31;

   typedef enum logic [PHASE_W-1:0] {
      PH_CALIBRATE = 3'd0,
      PH_PAD       = 3'd1,
      PH_ASCENT    = 3'd2,
      PH_DESCENT   = 3'd3,
      PH_LANDED    = 3'd4
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 2'd0,
      EV_LIFTOFF = 2'd1,
      EV_APOGEE  = 2'd2,
      EV_LANDED  = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SUM,
      OP_MEAN,
      OP_DEV,
      OP_DEV_END,
      OP_TRACK
   } lane_op_type;

   typedef struct packed {
      lane_op_type       op;
      logic [MULT_W-1:0] km;
      logic [MULT_W-1:0] kl;
   } lane_ctl_type;

   typedef struct packed {
      logic liftoff;
      logic stable;
   } lane_flag_type;

endpackage

`default_nettype wire

### rtl/flight_phase_detector.sv
// Top level of the flight phase detector: handshake, phase control and pressure windows.
//
// Usage: each request carries one sensor sample (three accelerations, three
// angular rates, one pressure). Every request produces exactly one response
// with the flight phase after that sample and an event code that is nonzero
// only on the sample that causes liftoff, apogee or landing.
// The first 2*CAL_HALF requests calibrate the means and deviations; after
// that the block watches for liftoff, apogee and landing in turn.
// A request accepted into the input register is evaluated there and its
// response is loaded into the response register. Throughput is one request per
// cycle while the receiver does not stall: the input and response registers
// are both updated in the same cycle, with all per-sample math between them.
// When the receiver stalls, the response register holds; a second request
// waits in the input register and req_stall rises only when both are full.
// Reset (synchronous) returns to calibration with zeroed statistics and
// the multiplier registers at their defaults. The window entries need no
// reset because calibration fills them before they are read.
// Configuration writes take effect at the edge at which csr_write_en is high. The user
// must make them while no request is in flight; the block itself does not enforce it.
`default_nettype none

module flight_phase_detector #(
   parameter int WINDOW_LEN = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_write_en,
   input  wire logic [fpd_pkg::REG_IDX_W-1:0]       csr_index,
   input  wire logic [fpd_pkg::MULT_W-1:0]          csr_wdata,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_accel_x,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_accel_y,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_accel_z,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_rate_x,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_rate_y,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]    req_rate_z,
   input  wire logic [fpd_pkg::P_W-1:0]             req_pressure,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [fpd_pkg::PHASE_W-1:0]              rsp_flight_phase,
   output logic [fpd_pkg::EVENT_W-1:0]              rsp_event_code
);

   localparam int PM_W  = fpd_pkg::PM_W;
   localparam int PD_W  = fpd_pkg::PD_W;
   localparam int SUM_W = PM_W + $clog2(WINDOW_LEN);
   localparam int KW_W  = $clog2(fpd_pkg::MULT_MAX * WINDOW_LEN + 1);
   localparam int TP_W  = KW_W + PD_W;
   localparam int CMP_W = TP_W + 1;

   // Handshake and input register.
   logic                            in_valid_ff;
   logic                            go;
   logic signed [fpd_pkg::SMP_W-1:0] smp_ff [fpd_pkg::NUM_LANES];
   logic [fpd_pkg::P_W-1:0]          pres_ff;

   // Configuration registers, with the window-scaled copies kept alongside.
   logic [fpd_pkg::MULT_W-1:0] km_ff, kl_ff;
   logic [KW_W-1:0]            kmw_ff, klw_ff;

   // Phase control.
   fpd_pkg::phase_type         phase_ff, phase_in;
   logic [fpd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   fpd_pkg::lane_op_type       lane_op;
   fpd_pkg::event_type         event_out;
   logic                       win_fill;
   logic                       win_slide;

   // Motion lanes.
   fpd_pkg::lane_ctl_type      lane_ctl;
   fpd_pkg::lane_flag_type     lane_flags [fpd_pkg::NUM_LANES];
   logic                       motion_stable;

   // Pressure statistics and windows.
   logic [PM_W-1:0]  pmean_ff, pmean_in;
   logic [PD_W-1:0]  pdev_ff, pdev_in;
   logic [PM_W-1:0]  older_ff [WINDOW_LEN];
   logic [PM_W-1:0]  newer_ff [WINDOW_LEN];
   logic [SUM_W-1:0] sum0_ff, sum0_in;
   logic [SUM_W-1:0] sum1_ff, sum1_in;

   logic [PM_W-1:0]   p16;
   logic signed [PM_W:0] pdiff;
   logic [PM_W-1:0]   pabs;
   logic [PM_W-1:0]   pcal_sum;
   logic [PM_W+3:0]   pcal_q;
   logic [PD_W-1:0]   pdev_sum;
   logic [PD_W:0]     pdev_rnd;
   logic [SUM_W-1:0]  sum0_slide, sum1_slide, fill_sum;
   logic [TP_W-1:0]   apo_prod, land_prod;
   logic [CMP_W-1:0]  apo_thr;
   logic              apogee;
   logic [SUM_W-1:0]  pw;
   logic signed [SUM_W:0] pland_diff;
   logic [SUM_W-1:0]  pland_abs;
   logic              p_stable;

   // Response register.
   logic                         rsp_valid_ff;
   logic [fpd_pkg::PHASE_W-1:0]  rsp_phase_ff;
   logic [fpd_pkg::EVENT_W-1:0]  rsp_event_ff;

   // A request in the input register is evaluated when the response slot is free.
   assign go        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         smp_ff[0] <= req_accel_x;
         smp_ff[1] <= req_accel_y;
         smp_ff[2] <= req_accel_z;
         smp_ff[3] <= req_rate_x;
         smp_ff[4] <= req_rate_y;
         smp_ff[5] <= req_rate_z;
         pres_ff   <= req_pressure;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         km_ff  <= fpd_pkg::KM_RESET;
         kl_ff  <= fpd_pkg::KL_RESET;
         kmw_ff <= KW_W'(fpd_pkg::KM_RESET * WINDOW_LEN);
         klw_ff <= KW_W'(fpd_pkg::KL_RESET * WINDOW_LEN);
      end else if (csr_write_en) begin
         case (csr_index)
            fpd_pkg::REG_LIFTOFF_APOGEE_MULT: begin
               km_ff  <= csr_wdata;
               kmw_ff <= KW_W'(csr_wdata * WINDOW_LEN);
            end
            fpd_pkg::REG_LANDING_MULT: begin
               kl_ff  <= csr_wdata;
               klw_ff <= KW_W'(csr_wdata * WINDOW_LEN);
            end
            default: begin
               km_ff <= km_ff;
            end
         endcase
      end
   end

   // Six motion channels share one control word.
   assign lane_ctl.op = lane_op;
   assign lane_ctl.km = km_ff;
   assign lane_ctl.kl = kl_ff;

   for (genvar g = 0; g < fpd_pkg::NUM_LANES; g++) begin : g_lane
      fpd_motion_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (smp_ff[g]),
         .flags  (lane_flags[g])
      );
   end

   always_comb begin
      motion_stable = 1'b1;
      for (int i = 0; i < fpd_pkg::NUM_LANES; i++) begin
         motion_stable = motion_stable && lane_flags[i].stable;
      end
   end

   // Pressure sample in Q.4 and its distance from the calibration mean.
   assign p16   = {pres_ff, 4'b0000};
   assign pdiff = $signed({1'b0, p16}) - $signed({1'b0, pmean_ff});
   assign pabs  = pdiff[PM_W] ? PM_W'(-pdiff) : PM_W'(pdiff);

   // Pressure calibration arithmetic.
   assign pcal_sum = pmean_ff + PM_W'(pres_ff);
   assign pcal_q   = ({pcal_sum, 4'b0000} + (PM_W + 4)'(fpd_pkg::CAL_RND)) >> fpd_pkg::CAL_LOG2;
   assign pdev_sum = pdev_ff + PD_W'(pabs);
   assign pdev_rnd = ({1'b0, pdev_sum} + (PD_W + 1)'(fpd_pkg::CAL_RND)) >> fpd_pkg::CAL_LOG2;

   always_comb begin
      pmean_in = pmean_ff;
      pdev_in  = pdev_ff;
      case (lane_op)
         fpd_pkg::OP_SUM:     pmean_in = pcal_sum;
         fpd_pkg::OP_MEAN:    pmean_in = PM_W'(pcal_q);
         fpd_pkg::OP_DEV:     pdev_in  = pdev_sum;
         fpd_pkg::OP_DEV_END: pdev_in  = PD_W'(pdev_rnd);
         default: begin
            pmean_in = pmean_ff;
            pdev_in  = pdev_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmean_ff <= '0;
         pdev_ff  <= '0;
      end else begin
         pmean_ff <= pmean_in;
         pdev_ff  <= pdev_in;
      end
   end

   // Window sums: the oldest newer entry moves into the older window.
   assign sum0_slide = sum0_ff + SUM_W'(newer_ff[0]) - SUM_W'(older_ff[0]);
   assign sum1_slide = sum1_ff + SUM_W'(p16) - SUM_W'(newer_ff[0]);
   assign fill_sum   = SUM_W'(pmean_ff) * SUM_W'(WINDOW_LEN);

   always_comb begin
      sum0_in = sum0_ff;
      sum1_in = sum1_ff;
      if (win_fill) begin
         sum0_in = fill_sum;
         sum1_in = fill_sum;
      end else if (win_slide) begin
         sum0_in = sum0_slide;
         sum1_in = sum1_slide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum0_ff <= '0;
         sum1_ff <= '0;
      end else begin
         sum0_ff <= sum0_in;
         sum1_ff <= sum1_in;
      end
   end

   // Window entries: filled with the mean at the end of calibration, then shifted.
   always_ff @(posedge clock) begin
      if (win_fill) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            older_ff[i] <= pmean_ff;
            newer_ff[i] <= pmean_ff;
         end
      end else if (win_slide) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            older_ff[i] <= older_ff[i + 1];
            newer_ff[i] <= newer_ff[i + 1];
         end
         older_ff[WINDOW_LEN - 1] <= newer_ff[0];
         newer_ff[WINDOW_LEN - 1] <= p16;
      end
   end

   // Apogee: the newer window's sum leads the older one's by the scaled deviation.
   assign apo_prod = kmw_ff * pdev_ff;
   assign apo_thr  = CMP_W'(sum0_slide) + CMP_W'(apo_prod);
   assign apogee   = CMP_W'(sum1_slide) > apo_thr;

   // Landing: pressure lies within the band around the newer window's mean.
   assign pw         = SUM_W'(p16) * SUM_W'(WINDOW_LEN);
   assign pland_diff = $signed({1'b0, pw}) - $signed({1'b0, sum1_ff});
   assign pland_abs  = pland_diff[SUM_W] ? SUM_W'(-pland_diff) : SUM_W'(pland_diff);
   assign land_prod  = klw_ff * pdev_ff;
   assign p_stable   = CMP_W'(pland_abs) < CMP_W'(land_prod);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (go) begin
         case (phase_ff)
            fpd_pkg::PH_CALIBRATE: begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == fpd_pkg::CAL_LAST) begin
                  phase_in = fpd_pkg::PH_PAD;
               end
            end
            fpd_pkg::PH_PAD: begin
               if (lane_flags[0].liftoff) begin
                  phase_in = fpd_pkg::PH_ASCENT;
               end
            end
            fpd_pkg::PH_ASCENT: begin
               if (apogee) begin
                  phase_in = fpd_pkg::PH_DESCENT;
               end
            end
            fpd_pkg::PH_DESCENT: begin
               if (motion_stable && p_stable) begin
                  phase_in = fpd_pkg::PH_LANDED;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Per-phase datapath controls and event code.
   always_comb begin
      lane_op   = fpd_pkg::OP_HOLD;
      win_fill  = 1'b0;
      win_slide = 1'b0;
      event_out = fpd_pkg::EV_NONE;
      if (go) begin
         case (phase_ff)
            fpd_pkg::PH_CALIBRATE: begin
               if (cnt_ff < fpd_pkg::CAL_MID) begin
                  lane_op = fpd_pkg::OP_SUM;
               end else if (cnt_ff == fpd_pkg::CAL_MID) begin
                  lane_op = fpd_pkg::OP_MEAN;
               end else if (cnt_ff < fpd_pkg::CAL_LAST) begin
                  lane_op = fpd_pkg::OP_DEV;
               end else begin
                  lane_op  = fpd_pkg::OP_DEV_END;
                  win_fill = 1'b1;
               end
            end
            fpd_pkg::PH_PAD: begin
               win_slide = 1'b1;
               if (lane_flags[0].liftoff) begin
                  event_out = fpd_pkg::EV_LIFTOFF;
               end
            end
            fpd_pkg::PH_ASCENT: begin
               win_slide = 1'b1;
               lane_op   = fpd_pkg::OP_TRACK;
               if (apogee) begin
                  event_out = fpd_pkg::EV_APOGEE;
               end
            end
            fpd_pkg::PH_DESCENT: begin
               win_slide = 1'b1;
               lane_op   = fpd_pkg::OP_TRACK;
               if (motion_stable && p_stable) begin
                  event_out = fpd_pkg::EV_LANDED;
               end
            end
            default: begin
               lane_op = fpd_pkg::OP_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fpd_pkg::PH_CALIBRATE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_phase_ff <= phase_in;
         rsp_event_ff <= event_out;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_flight_phase = rsp_phase_ff;
   assign rsp_event_code   = rsp_event_ff;

endmodule

`default_nettype wire

### rtl/fpd_motion_lane.sv
// One motion channel: mean and deviation state with its threshold tests.
`default_nettype none

module fpd_motion_lane (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fpd_pkg::lane_ctl_type              ctl,
   input  wire logic signed [fpd_pkg::SMP_W-1:0]   sample,
   output fpd_pkg::lane_flag_type                  flags
);

   localparam int MM_W = fpd_pkg::MM_W;
   localparam int MD_W = fpd_pkg::MD_W;
   localparam int PR_W = fpd_pkg::MULT_W + MD_W;

   logic signed [MM_W-1:0] mean_ff, mean_in;
   logic [MD_W-1:0]        dev_ff, dev_in;

   logic signed [MM_W:0]   s16;
   logic signed [MM_W:0]   diff;
   logic [MM_W:0]          absdiff;
   logic signed [MM_W-1:0] cal_sum;
   logic signed [MM_W+3:0] cal_q;
   logic [MD_W:0]          dev_sum;
   logic [MD_W:0]          dev_rnd;
   logic signed [MM_W+2:0] s25;
   logic signed [MM_W+2:0] m25;
   logic signed [MM_W+2:0] trk;
   logic [PR_W-1:0]        lift_prod;
   logic [PR_W-1:0]        land_prod;

   // Sample in Q.4 and its distance from the current mean.
   assign s16     = {{(MM_W + 1 - fpd_pkg::SMP_W - 4){sample[fpd_pkg::SMP_W-1]}}, sample, 4'b0000};
   assign diff    = s16 - {mean_ff[MM_W-1], mean_ff};
   assign absdiff = diff[MM_W] ? (~diff + 1'b1) : diff;

   // Calibration mean: running sum, then rounded average scaled to Q.4.
   assign cal_sum = mean_ff + sample;
   assign cal_q   = $signed({cal_sum, 4'b0000}) + $signed((MM_W + 4)'(fpd_pkg::CAL_RND));

   // Calibration deviation: running sum of distances, then rounded average.
   assign dev_sum = {1'b0, dev_ff} + (MD_W + 1)'(absdiff);
   assign dev_rnd = (dev_sum + (MD_W + 1)'(fpd_pkg::CAL_RND)) >> fpd_pkg::CAL_LOG2;

   // Flight tracking: a quarter of the new sample, three quarters of the old mean.
   assign s25 = s16;
   assign m25 = mean_ff;
   assign trk = s25 + m25 + (m25 <<< 1) + $signed((MM_W + 3)'(fpd_pkg::TRK_RND));

   // State update.
   always_comb begin
      mean_in = mean_ff;
      dev_in  = dev_ff;
      case (ctl.op)
         fpd_pkg::OP_SUM:     mean_in = cal_sum;
         fpd_pkg::OP_MEAN:    mean_in = MM_W'(cal_q >>> fpd_pkg::CAL_LOG2);
         fpd_pkg::OP_DEV:     dev_in  = MD_W'(dev_sum);
         fpd_pkg::OP_DEV_END: dev_in  = MD_W'(dev_rnd);
         fpd_pkg::OP_TRACK:   mean_in = MM_W'(trk >>> fpd_pkg::TRK_SHIFT);
         default: begin
            mean_in = mean_ff;
            dev_in  = dev_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         dev_ff  <= '0;
      end else begin
         mean_ff <= mean_in;
         dev_ff  <= dev_in;
      end
   end

   // Threshold tests against the mean as it stands before this request.
   assign lift_prod = ctl.km * dev_ff;
   assign land_prod = ctl.kl * dev_ff;

   assign flags.liftoff = $signed({{(PR_W - MM_W){diff[MM_W]}}, diff})
                          > $signed({1'b0, lift_prod});
   assign flags.stable  = PR_W'(absdiff) < land_prod;

endmodule

`default_nettype wire

### test/flight_phase_detector_tb.sv
// Self-checking testbench for the flight phase detector: one full flight with a scoreboard.

module flight_phase_detector_tb;
   import fpd_pkg::*;

   localparam int WIN         = 6;
   localparam int IDLE_PCT    = 30;
   localparam int HOLD_AT     = 60;
   localparam int HOLD_LEN    = 48;
   localparam int QUIET_LIMIT = 1000;
   localparam logic [MULT_W-1:0] MULT_TOP = MULT_W'(MULT_MAX);
   localparam logic [MULT_W-1:0] CLIMB_MULTS [3] = '{MULT_TOP, 4'd1, 4'd7};

   // One sensor sample, lanes ordered accel x/y/z then rate x/y/z.
   typedef struct packed {
      logic [NUM_LANES-1:0][SMP_W-1:0] lane;
      logic [P_W-1:0]                  baro;
   } sample_t;

   typedef struct {
      phase_type phase;
      event_type ev;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                csr_write_en = 1'b0;
   logic [REG_IDX_W-1:0] csr_index  = REG_LIFTOFF_APOGEE_MULT;
   logic [MULT_W-1:0]   csr_wdata   = '0;

   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   logic signed [SMP_W-1:0] req_accel_x  = '0;
   logic signed [SMP_W-1:0] req_accel_y  = '0;
   logic signed [SMP_W-1:0] req_accel_z  = '0;
   logic signed [SMP_W-1:0] req_rate_x   = '0;
   logic signed [SMP_W-1:0] req_rate_y   = '0;
   logic signed [SMP_W-1:0] req_rate_z   = '0;
   logic [P_W-1:0]          req_pressure = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PHASE_W-1:0]  rsp_flight_phase;
   logic [EVENT_W-1:0]  rsp_event_code;

   // Requests waiting to be offered, and phase/event results still owed.
   sample_t  pending_samples[$];
   outcome_t flight_expect[$];

   // Shadow of the detector: phase, calibration statistics and pressure windows.
   phase_type         flight_now = PH_CALIBRATE;
   int                cal_seen   = 0;
   longint            lane_mean[NUM_LANES] = '{default: 0};
   longint            lane_dev[NUM_LANES]  = '{default: 0};
   longint            baro_mean = 0;
   longint            baro_dev  = 0;
   longint            older_win[WIN] = '{default: 0};
   longint            newer_win[WIN] = '{default: 0};
   longint            older_sum = 0;
   longint            newer_sum = 0;
   logic [MULT_W-1:0] km_now = KM_RESET;
   logic [MULT_W-1:0] kl_now = KL_RESET;

   // Stimulus shaping shared by the generator tasks.
   longint lane_rest[NUM_LANES];
   longint baro_rest;
   longint baro_walk;
   int     spread;
   bit     calm_stretch = 1'b0;

   // Bookkeeping.
   sample_t  taken;
   sample_t  offer;
   outcome_t want;
   int       taken_count  = 0;
   int       rsp_seen     = 0;
   int       events_seen  = 0;
   int       fail_count   = 0;
   int       hold_left    = 0;
   int       quiet_cycles = 0;

   flight_phase_detector #(.WINDOW_LEN(WIN)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_rate_x       (req_rate_x),
      .req_rate_y       (req_rate_y),
      .req_rate_z       (req_rate_z),
      .req_pressure     (req_pressure),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_flight_phase (rsp_flight_phase),
      .rsp_event_code   (rsp_event_code)
   );

   always #2 clock = ~clock;

   // Division rounded to nearest, halves toward plus infinity (positive divisor).
   function automatic longint div_round(input longint num, input longint den);
      longint n;
      longint q;
      n = num + den / 2;
      q = n / den;
      if (n % den != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint lane_value(input sample_t s, input int i);
      return longint'($signed(s.lane[i]));
   endfunction

   // Both windows advance by one: the oldest newer entry moves into the older window.
   task automatic shift_windows(input longint p16);
      longint moved;
      int     i;
      moved = newer_win[0];
      older_sum += moved - older_win[0];
      for (i = 0; i < WIN - 1; i++) older_win[i] = older_win[i + 1];
      older_win[WIN - 1] = moved;
      newer_sum += p16 - moved;
      for (i = 0; i < WIN - 1; i++) newer_win[i] = newer_win[i + 1];
      newer_win[WIN - 1] = p16;
   endtask

   // In flight the motion means follow a quarter-new, three-quarter-old average.
   task automatic track_means(input sample_t s);
      int i;
      for (i = 0; i < NUM_LANES; i++)
         lane_mean[i] = div_round(lane_value(s, i) * 16 + 3 * lane_mean[i], 4);
   endtask

   // Advance the shadow detector by one accepted request and queue its result.
   task automatic predict_sample(input sample_t s);
      longint    p16;
      longint    km;
      longint    kl;
      event_type ev;
      bit        steady;
      outcome_t  res;
      int        i;
      p16 = longint'(s.baro) * 16;
      km  = longint'(km_now);
      kl  = longint'(kl_now);
      ev  = EV_NONE;
      case (flight_now)
         PH_CALIBRATE: begin
            if (cal_seen < CAL_HALF) begin
               for (i = 0; i < NUM_LANES; i++) lane_mean[i] += lane_value(s, i);
               baro_mean += longint'(s.baro);
               if (cal_seen == CAL_HALF - 1) begin
                  for (i = 0; i < NUM_LANES; i++)
                     lane_mean[i] = div_round(lane_mean[i] * 16, CAL_HALF);
                  baro_mean = div_round(baro_mean * 16, CAL_HALF);
               end
            end else begin
               for (i = 0; i < NUM_LANES; i++)
                  lane_dev[i] += magnitude(lane_value(s, i) * 16 - lane_mean[i]);
               baro_dev += magnitude(p16 - baro_mean);
               if (cal_seen == 2 * CAL_HALF - 1) begin
                  for (i = 0; i < NUM_LANES; i++) lane_dev[i] = div_round(lane_dev[i], CAL_HALF);
                  baro_dev = div_round(baro_dev, CAL_HALF);
                  for (i = 0; i < WIN; i++) begin
                     older_win[i] = baro_mean;
                     newer_win[i] = baro_mean;
                  end
                  older_sum  = baro_mean * WIN;
                  newer_sum  = baro_mean * WIN;
                  flight_now = PH_PAD;
               end
            end
            cal_seen++;
         end
         PH_PAD: begin
            if (lane_value(s, 0) * 16 - lane_mean[0] > km * lane_dev[0]) begin
               flight_now = PH_ASCENT;
               ev         = EV_LIFTOFF;
            end
            shift_windows(p16);
         end
         PH_ASCENT: begin
            shift_windows(p16);
            track_means(s);
            if (newer_sum > older_sum + WIN * km * baro_dev) begin
               flight_now = PH_DESCENT;
               ev         = EV_APOGEE;
            end
         end
         PH_DESCENT: begin
            // The landing test sees the statistics from before this sample.
            steady = 1'b1;
            for (i = 0; i < NUM_LANES; i++)
               if (!(magnitude(lane_value(s, i) * 16 - lane_mean[i]) < kl * lane_dev[i]))
                  steady = 1'b0;
            if (!(magnitude(p16 * WIN - newer_sum) < WIN * kl * baro_dev)) steady = 1'b0;
            if (steady) begin
               flight_now = PH_LANDED;
               ev         = EV_LANDED;
            end
            track_means(s);
            shift_windows(p16);
         end
         default: ;
      endcase
      res.phase = flight_now;
      res.ev    = ev;
      flight_expect.push_back(res);
   endtask

   // Sender: offers queued requests, holds a stalled one, idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.lane[0] = req_accel_x;
            taken.lane[1] = req_accel_y;
            taken.lane[2] = req_accel_z;
            taken.lane[3] = req_rate_x;
            taken.lane[4] = req_rate_y;
            taken.lane[5] = req_rate_z;
            taken.baro    = req_pressure;
            predict_sample(taken);
            taken_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 &&
                (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
               offer = pending_samples.pop_front();
               req_valid    <= 1'b1;
               req_accel_x  <= offer.lane[0];
               req_accel_y  <= offer.lane[1];
               req_accel_z  <= offer.lane[2];
               req_rate_x   <= offer.lane[3];
               req_rate_y   <= offer.lane[4];
               req_rate_z   <= offer.lane[5];
               req_pressure <= offer.baro;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each response against the oldest owed result, stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (flight_expect.size() == 0) begin
               $error("response with no request outstanding: flight_phase %0d, event_code %0d",
                      rsp_flight_phase, rsp_event_code);
               fail_count++;
            end else begin
               want = flight_expect.pop_front();
               if (want.ev != EV_NONE) events_seen++;
               if (rsp_flight_phase !== want.phase) begin
                  $error("flight_phase: expected %0d, actual %0d", want.phase, rsp_flight_phase);
                  fail_count++;
               end
               if (rsp_event_code !== want.ev) begin
                  $error("event_code: expected %0d, actual %0d", want.ev, rsp_event_code);
                  fail_count++;
               end
            end
            rsp_seen++;
            // One long hold-off so that the block fills and stalls its input.
            if (rsp_seen == HOLD_AT) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm_stretch) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles.", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic longint jitter(input int amp);
      return longint'($urandom_range(2 * amp)) - amp;
   endfunction

   function automatic logic [SMP_W-1:0] clip_lane(input longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return SMP_W'(v);
   endfunction

   function automatic logic [P_W-1:0] clip_baro(input longint v);
      if (v < 0) return '0;
      if (v > 64'hFF_FFFF) return '1;
      return P_W'(v);
   endfunction

   // A sample close to the resting attitude, as on the pad or after landing.
   function automatic sample_t settled_sample(input int amp, input longint baro, input int b_amp);
      sample_t s;
      int      i;
      for (i = 0; i < NUM_LANES; i++) s.lane[i] = clip_lane(lane_rest[i] + jitter(amp));
      s.baro = clip_baro(baro + jitter(b_amp));
      return s;
   endfunction

   // A sample with every motion lane drawn over its full range.
   function automatic sample_t wild_sample(input longint baro);
      sample_t s;
      int      i;
      for (i = 0; i < NUM_LANES; i++) s.lane[i] = $urandom;
      s.baro = clip_baro(baro);
      return s;
   endfunction

   // Largest accel_x that stays at or below the liftoff threshold.
   function automatic longint liftoff_cap();
      longint cap;
      cap = (lane_mean[0] + longint'(km_now) * lane_dev[0]) >>> 4;
      if (cap > 32767) cap = 32767;
      if (cap < -32768) cap = -32768;
      return cap;
   endfunction

   // Waits at the falling edge until every request is answered.
   task automatic settle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || flight_expect.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [MULT_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_LIFTOFF_APOGEE_MULT) km_now = val;
      else kl_now = val;
      @(negedge clock);
   endtask

   // Pad samples that stay below the liftoff threshold, near it most of the time.
   task automatic queue_pad_batch(input int count, input int junk_pct);
      sample_t s;
      longint  cap;
      int      n;
      int      i;
      cap = liftoff_cap();
      for (n = 0; n < count; n++) begin
         s = settled_sample(spread, baro_rest, spread);
         if ($urandom_range(99) < 40)
            for (i = 1; i < NUM_LANES; i++) s.lane[i] = $urandom;
         if ($urandom_range(99) < 70) s.lane[0] = clip_lane(cap - $urandom_range(2 * spread));
         else s.lane[0] = clip_lane(cap - $urandom_range(int'(cap) + 32768));
         if ($urandom_range(99) < junk_pct) s.baro = $urandom;
         pending_samples.push_back(s);
      end
   endtask

   initial begin : stimulus
      sample_t s;
      longint  rise;
      int      i;
      int      n;
      int      k;
      int      tries;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Calibration: each lane hovers around a random resting value.
      spread = $urandom_range(200, 20);
      for (i = 0; i < NUM_LANES; i++) lane_rest[i] = longint'($urandom_range(4000)) - 2000;
      baro_rest = $urandom_range(4000000, 100000);
      baro_walk = baro_rest;
      for (n = 0; n < 2 * CAL_HALF; n++)
         pending_samples.push_back(settled_sample(spread, baro_rest, spread));
      settle();

      // Pad, directed: field extremes with accel_x held low, then the threshold itself.
      write_reg(REG_LIFTOFF_APOGEE_MULT, MULT_TOP);
      for (n = 0; n < 4; n++) begin
         for (i = 1; i < NUM_LANES; i++)
            s.lane[i] = (n == 0) ? 16'h8000 : (n == 1) ? 16'h7FFF : (n == 2) ? 16'h0000 : 16'hFFFF;
         s.lane[0] = 16'h8000;
         s.baro    = (n == 0) ? 24'h000000 : (n == 1) ? 24'hFFFFFF : (n == 2) ? 24'h000001 : 24'h800000;
         pending_samples.push_back(s);
      end
      s = settled_sample(spread, baro_rest, spread);
      s.lane[0] = clip_lane(liftoff_cap());
      pending_samples.push_back(s);
      settle();

      // Pad, random: multiplier one with some junk pressure, then zero multiplier.
      write_reg(REG_LIFTOFF_APOGEE_MULT, 4'd1);
      queue_pad_batch(130, 5);
      settle();
      write_reg(REG_LIFTOFF_APOGEE_MULT, 4'd0);
      calm_stretch = 1'b1;
      queue_pad_batch(130, 0);
      settle();
      calm_stretch = 1'b0;

      // Liftoff under a zero multiplier: the smallest positive excess fires.
      s = settled_sample(spread, baro_rest, spread);
      s.lane[0] = clip_lane(liftoff_cap() + 1);
      pending_samples.push_back(s);
      settle();

      // Ascent: full-scale lanes, then falling pressure with occasional upticks.
      write_reg(REG_LIFTOFF_APOGEE_MULT, MULT_TOP);
      baro_walk = baro_rest;
      for (n = 0; n < 2; n++) begin
         baro_walk -= spread;
         for (i = 0; i < NUM_LANES; i++) s.lane[i] = (n == 0) ? 16'h7FFF : 16'h8000;
         s.baro = clip_baro(baro_walk);
         pending_samples.push_back(s);
      end
      for (k = 0; k < 3; k++) begin
         if (k != 0) write_reg(REG_LIFTOFF_APOGEE_MULT, CLIMB_MULTS[k]);
         for (n = 0; n < 60; n++) begin
            if ($urandom_range(99) < 10) baro_walk += $urandom_range(spread);
            else baro_walk -= $urandom_range(spread);
            if ($urandom_range(99) < 80) s = wild_sample(baro_walk);
            else s = settled_sample(spread, baro_walk, 0);
            pending_samples.push_back(s);
         end
         settle();
      end

      // Apogee: pressure turns and climbs until the newer window clears the threshold.
      write_reg(REG_LIFTOFF_APOGEE_MULT, KM_RESET);
      rise  = longint'(km_now) * baro_dev / 96 + 1 + $urandom_range(spread);
      tries = 0;
      while (flight_now == PH_ASCENT && tries < 20) begin
         for (n = 0; n < WIN; n++) begin
            baro_walk += rise + $urandom_range(spread / 4);
            pending_samples.push_back(wild_sample(baro_walk));
         end
         settle();
         tries++;
      end

      // Descent: tumbling lanes and rising pressure, far from any landing band.
      write_reg(REG_LANDING_MULT, 4'd1);
      for (n = 0; n < 200; n++) begin
         baro_walk += $urandom_range(spread);
         if ($urandom_range(99) < 85) s = wild_sample(baro_walk);
         else s = settled_sample(spread, baro_walk, 0);
         pending_samples.push_back(s);
      end
      settle();

      // At rest with a zero landing multiplier: the strict band never holds.
      write_reg(REG_LANDING_MULT, 4'd0);
      for (n = 0; n < 40; n++)
         pending_samples.push_back(settled_sample(spread / 8, baro_walk, spread / 8));
      settle();

      // Widest landing band: the vehicle settles and lands.
      write_reg(REG_LANDING_MULT, MULT_TOP);
      tries = 0;
      while (flight_now == PH_DESCENT && tries < 20) begin
         for (n = 0; n < 8; n++)
            pending_samples.push_back(settled_sample(spread / 8, baro_walk, spread / 8));
         settle();
         tries++;
      end

      // Once landed the block must stay put whatever arrives.
      for (n = 0; n < 10; n++)
         pending_samples.push_back(wild_sample($urandom_range(24'hFFFFFF)));
      settle();

      $display("Flight run: %0d samples accepted, %0d responses checked, %0d phase events.",
               taken_count, rsp_seen, events_seen);
      $display("Multipliers swept from 0 to 15 across pad, ascent and descent; ended in %s.",
               flight_now.name());
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### flight_phase_detector.f
rtl/fpd_pkg.sv
rtl/fpd_motion_lane.sv
rtl/flight_phase_detector.sv
test/flight_phase_detector_tb.sv
